// ===== design/waypoint_chunk_reassembly_top_macros.svh =====
// Assertion helpers for the waypoint chunk reassembly block.
// Both expect a clock named clk and a synchronous active-high reset named rst.
`ifndef WAYPOINT_CHUNK_REASSEMBLY_TOP_MACROS_SVH
`define WAYPOINT_CHUNK_REASSEMBLY_TOP_MACROS_SVH

// Same-cycle implication.
`define WCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define WCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/wcr_pkg.sv =====
package wcr_pkg;

  typedef enum logic [2:0] {
    ACT_DROP  = 3'd0,
    ACT_FWD   = 3'd1,
    ACT_STORE = 3'd2,
    ACT_HIT   = 3'd3,
    ACT_MISS  = 3'd4
  } act_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } coord_t;

  localparam logic       OP_PACKET   = 1'b0;
  localparam logic       OP_READ     = 1'b1;
  localparam logic [7:0] UPLINK_MARK = 8'hFD;
  localparam logic [6:0] CHUNK_BYTES = 7'd14;

  localparam logic [7:0] CFG_MAGIC  = 8'd0;
  localparam logic [7:0] CFG_UPLINK = 8'd1;

  localparam logic [7:0] MAGIC_RESET = 8'd197;

endpackage

// ===== design/waypoint_chunk_reassembly_top.sv =====
// Waypoint chunk reassembly: takes received radio packets and waypoint reads on one stream
// (s_tuser = 0 packet, 1 read) and gives one result item per input item. Each item first
// reads the waypoint memory (one synchronous read port), then is decided, written back and
// loaded into the output register. The next item is taken while a result still waits on
// the master side; the block holds only when a second result would have nowhere to go.
// Chunk presence is kept in one flip-flop per waypoint, so no clearing pass follows reset.
// Configuration writes (index 0 telemetry magic, 1 uplink enable) are taken at any time and
// should only be issued while the block is idle.
`include "waypoint_chunk_reassembly_top_macros.svh"

module waypoint_chunk_reassembly_top import wcr_pkg::*; #(
  parameter int MAX_POINTS = 32
) (
  input  logic         clk,
  input  logic         rst,
  // configuration
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [7:0]   cfg_data,
  // input items
  input  logic         s_tvalid,
  output logic         s_tready,
  // packet_length[6:0], first_byte[14:7], second_byte[22:15], coord_x_in[54:23],
  // coord_y_in[86:55], coord_z_in[118:87], read_index[134:119], zero pad[135]
  input  logic [135:0] s_tdata,
  input  logic [0:0]   s_tuser,   // op
  // result items
  output logic         m_tvalid,
  input  logic         m_tready,
  // ack_seq[7:0], mission_ready[8], waypoint_count[14:9], coord_x_out[46:15],
  // coord_y_out[78:47], coord_z_out[110:79], zero pad[111]
  output logic [111:0] m_tdata,
  output logic [2:0]   m_tuser    // action
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int TW = $clog2(MAX_POINTS + 1);

  state_t state, state_next;

  // configuration registers
  logic [7:0] magic;
  logic       uplink_en;

  // latched item
  logic        it_op;
  logic [6:0]  it_len;
  logic [7:0]  it_b0;
  logic [7:0]  it_b1;
  coord_t      it_coord;
  logic [15:0] it_idx;

  // mission state
  logic [MAX_POINTS-1:0] present, present_next;
  logic [TW-1:0]         total, total_next;
  logic                  ready_flag, ready_next;

  // output register
  logic       out_valid;
  act_t       out_action;
  logic [7:0] out_ack;
  logic       out_ready;
  logic [5:0] out_count;
  coord_t     out_coord;

  // memory
  logic          mem_we;
  logic [AW-1:0] mem_raddr;
  coord_t        mem_rdata;

  logic       accept, out_free, finish, store_c, hit_c, ready_calc, ready_now;
  act_t       act_c;
  logic [7:0] ack_c;
  logic [5:0] count_c;
  coord_t     coord_c;
  logic [31:0] total_wide;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tuser  = out_action;
  assign m_tdata  = {1'b0, out_coord.z, out_coord.y, out_coord.x, out_count, out_ready, out_ack};

  always_ff @(posedge clk) begin
    if (rst) begin
      magic     <= MAGIC_RESET;
      uplink_en <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAGIC:  magic     <= cfg_data;
        CFG_UPLINK: uplink_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // read at the incoming index, then hold the latched one while waiting
  assign mem_raddr = (state == ST_IDLE) ? s_tdata[119 +: AW] : it_idx[AW-1:0];

  wcr_store #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (it_b0[AW-1:0]),
    .wdata (it_coord),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      it_op    <= s_tuser[0];
      it_len   <= s_tdata[6:0];
      it_b0    <= s_tdata[14:7];
      it_b1    <= s_tdata[22:15];
      it_coord <= {s_tdata[118:87], s_tdata[86:55], s_tdata[54:23]};
      it_idx   <= s_tdata[134:119];
    end
  end

  // classify the latched item and work out the state after it
  always_comb begin
    act_c        = ACT_DROP;
    store_c      = 1'b0;
    hit_c        = 1'b0;
    present_next = present;
    ready_calc   = 1'b1;
    if (it_op == OP_READ) begin
      hit_c = (it_idx < 16'(total)) && (it_idx < 16'(MAX_POINTS)) && present[it_idx[AW-1:0]];
      act_c = hit_c ? ACT_HIT : ACT_MISS;
    end else if (it_len == 7'd0) begin
      act_c = ACT_DROP;
    end else if (it_b0 == UPLINK_MARK) begin
      act_c = uplink_en ? ACT_FWD : ACT_DROP;
    end else if (it_b0 == magic) begin
      act_c = ACT_DROP;
    end else if (it_len < CHUNK_BYTES) begin
      act_c = ACT_DROP;
    end else if (it_b0 >= 8'(MAX_POINTS) || it_b1 == 8'd0 || it_b1 > 8'(MAX_POINTS)) begin
      act_c = ACT_DROP;
    end else begin
      act_c   = ACT_STORE;
      store_c = 1'b1;
      present_next[it_b0[AW-1:0]] = 1'b1;
    end
    total_next = store_c ? TW'(it_b1) : total;
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (TW'(i) < total_next && !present_next[i]) begin
        ready_calc = 1'b0;
      end
    end
    ready_next = store_c ? ready_calc : ready_flag;
    total_wide = 32'(total_next);
    count_c    = ready_next ? total_wide[5:0] : 6'd0;
    ack_c      = store_c ? it_b0 : 8'd0;
    coord_c    = hit_c ? mem_rdata : '0;
  end

  assign finish = (state == ST_EXEC) && out_free;
  assign mem_we = finish && store_c;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_EXEC;
      ST_EXEC: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      present    <= '0;
      total      <= '0;
      ready_flag <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        present    <= present_next;
        total      <= total_next;
        ready_flag <= ready_next;
        out_valid  <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_action <= act_c;
      out_ack    <= ack_c;
      out_ready  <= ready_next;
      out_count  <= count_c;
      out_coord  <= coord_c;
    end
  end

  // readiness of the held state, for checking only
  always_comb begin
    ready_now = 1'b1;
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (TW'(i) < total && !present[i]) begin
        ready_now = 1'b0;
      end
    end
  end

  `WCR_ASSERT_NOW(a_ready_consistent, ready_flag, ready_now, "ready set with a chunk missing")
  `WCR_ASSERT_NEXT(a_one_in_flight, accept, !s_tready, "second item taken before the first ended")
  `WCR_ASSERT_NOW(a_write_on_finish, mem_we, (state == ST_EXEC) && out_free && !it_op, "store write outside a packet finish")

endmodule

// ===== design/wcr_store.sv =====
module wcr_store import wcr_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  coord_t        wdata,
  input  logic [AW-1:0] raddr,
  output coord_t        rdata
);

  coord_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
